// ===== rtl/kmq_pkg.sv =====
package kmq_pkg;

   // Frame and cluster geometry
   localparam int NUM_CLUSTERS = 4;
   localparam int FRAME_MAX    = 65536;

   localparam int     PIX_W   = 8;
   localparam int     PIX_AW  = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
   localparam int     COUNT_W = $clog2(FRAME_MAX + 1);
   localparam longint SUM_MAX = longint'(FRAME_MAX) * 255;
   localparam int     SUM_W   = $clog2(SUM_MAX + 1);
   localparam int     LBL_W   = $clog2(NUM_CLUSTERS);

   // Register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INIT_C0    = 3'd0,
      CSR_INIT_C1    = 3'd1,
      CSR_INIT_C2    = 3'd2,
      CSR_INIT_C3    = 3'd3,
      CSR_MAX_PASSES = 3'd4
   } csr_index_type;

   typedef logic [PIX_W-1:0]   pixel_type;
   typedef logic [PIX_AW-1:0]  addr_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [SUM_W-1:0]   sum_type;
   typedef logic [LBL_W-1:0]   label_type;
   typedef pixel_type [NUM_CLUSTERS-1:0] center_vec_type;

   typedef struct packed {
      label_type lbl;
      pixel_type val;
   } near_type;

   function automatic pixel_type abs_diff(pixel_type a, pixel_type b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // Nearest centre by absolute distance; ties keep the lower index
   function automatic near_type nearest(pixel_type px, center_vec_type c);
      near_type  best;
      pixel_type best_d;
      pixel_type d;
      best.lbl = '0;
      best.val = c[0];
      best_d   = abs_diff(px, c[0]);
      for (int j = 1; j < NUM_CLUSTERS; j++) begin
         d = abs_diff(px, c[j]);
         if (d < best_d) begin
            best_d   = d;
            best.lbl = LBL_W'(j);
            best.val = c[j];
         end
      end
      return best;
   endfunction

endpackage

// ===== rtl/kmq_pixel_ram.sv =====
module kmq_pixel_ram (
   input  logic               clock,
   input  logic               wr_en,
   input  kmq_pkg::addr_type  wr_addr,
   input  kmq_pkg::pixel_type wr_data,
   input  logic               rd_en,
   input  kmq_pkg::addr_type  rd_addr,
   output kmq_pkg::pixel_type rd_data
);
   import kmq_pkg::*;

   pixel_type mem [FRAME_MAX];
   pixel_type rd_data_ff;

   // Frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/kmq_divider.sv =====
module kmq_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  kmq_pkg::sum_type  dividend,
   input  kmq_pkg::count_type divisor,
   output logic              done,
   output kmq_pkg::sum_type  quotient
);
   import kmq_pkg::*;

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   count_type        rem_ff;
   count_type        dvs_ff;
   sum_type          quo_ff;

   logic [COUNT_W:0] rem_sh;
   logic [COUNT_W:0] rem_diff;
   logic             fits;
   count_type        rem_in;
   sum_type          quo_in;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
      rem_diff = rem_sh - {1'b0, dvs_ff};
      fits     = (rem_sh >= {1'b0, dvs_ff});
      rem_in   = fits ? rem_diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
      quo_in   = {quo_ff[SUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
            cnt_ff  <= CNT_W'(SUM_W);
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/grayscale_kmeans_quantizer.sv =====
// Channel   Ports                                      Handshake
// request   req_func, req_pixel, req_last              start high, busy low
// response  rsp_value, rsp_label, rsp_last_out,        rsp_valid, one cycle
//           rsp_converged
// config    csr_index, csr_wdata                       csr_we, one cycle
//
// Loads and reads may come every cycle while idle. A read's result passes through
// the store read register and the output register after the read is taken.
// The load marked last starts clustering: each pass clears the sums, scans the
// store, drains the scan pipeline and divides each non-empty cluster on the shared
// divider, ending early once no centre moves; at most max_passes passes.
// Reset is synchronous and leaves the frame store as it was; no receiver stall.
module grayscale_kmeans_quantizer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  kmq_pkg::pixel_type                  req_pixel,
   input  logic                                req_last,
   output logic                                rsp_valid,
   output kmq_pkg::pixel_type                  rsp_value,
   output logic [1:0]                          rsp_label,
   output logic                                rsp_last_out,
   output logic                                rsp_converged,
   input  logic                                csr_we,
   input  logic [kmq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [kmq_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import kmq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_CLEAR,
      S_SCAN,
      S_DRAIN,
      S_DIV_SEL,
      S_DIV_WAIT,
      S_PASS_END
   } state_type;

   state_type      state_ff;
   pixel_type      init_ff [4];
   pixel_type      max_passes_ff;
   count_type      pix_count_ff;
   count_type      rd_ptr_ff;
   logic           frame_ready_ff;
   center_vec_type centers_ff;
   sum_type        sums_ff   [NUM_CLUSTERS];
   count_type      counts_ff [NUM_CLUSTERS];
   pixel_type      pass_ff;
   logic           conv_ff;
   logic           changed_ff;
   label_type      div_idx_ff;
   count_type      scan_cnt_ff;
   logic           s1_v_ff;
   logic           s2_v_ff;
   label_type      s2_lbl_ff;
   pixel_type      s2_px_ff;
   logic           rd_v_ff;
   logic           rd_last_ff;
   logic           rsp_valid_ff;
   pixel_type      rsp_value_ff;
   logic [1:0]     rsp_label_ff;
   logic           rsp_last_ff;
   logic           rsp_conv_ff;

   logic           accept;
   logic           load_acc;
   logic           read_acc;
   count_type      load_base;
   logic           load_room;
   logic           mem_re;
   addr_type       mem_raddr;
   pixel_type      mem_q;
   near_type       near;
   logic [LBL_W+1:0] lbl_ext;
   logic           last_idx;
   logic           div_start;
   logic           div_done;
   sum_type        div_quo;
   pixel_type      mean_val;

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign load_acc = accept && !req_func;
   assign read_acc = accept && req_func && frame_ready_ff && (rd_ptr_ff < pix_count_ff);

   // A load after a processed frame opens a new frame at address zero
   assign load_base = frame_ready_ff ? '0 : pix_count_ff;
   assign load_room = (load_base < COUNT_W'(FRAME_MAX));

   // Read port serves the clustering scan or the readout
   assign mem_re    = read_acc || (state_ff == S_SCAN);
   assign mem_raddr = (state_ff == S_SCAN) ? scan_cnt_ff[PIX_AW-1:0] : rd_ptr_ff[PIX_AW-1:0];

   kmq_pixel_ram u_ram (
      .clock   (clock),
      .wr_en   (load_acc && load_room),
      .wr_addr (load_base[PIX_AW-1:0]),
      .wr_data (req_pixel),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_q)
   );

   // Nearest centre of the word coming out of the store
   assign near    = nearest(mem_q, centers_ff);
   assign lbl_ext = {2'b00, near.lbl};

   // Shared divider for the cluster means
   assign last_idx   = (div_idx_ff == LBL_W'(NUM_CLUSTERS - 1));
   assign div_start  = (state_ff == S_DIV_SEL) && (counts_ff[div_idx_ff] != '0);
   assign mean_val   = div_quo[PIX_W-1:0];

   kmq_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sums_ff[div_idx_ff]),
      .divisor  (counts_ff[div_idx_ff]),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         init_ff[0]     <= 8'd0;
         init_ff[1]     <= 8'd85;
         init_ff[2]     <= 8'd170;
         init_ff[3]     <= 8'd255;
         max_passes_ff  <= 8'd64;
         pix_count_ff   <= '0;
         rd_ptr_ff      <= '0;
         frame_ready_ff <= 1'b0;
         pass_ff        <= '0;
         conv_ff        <= 1'b0;
         changed_ff     <= 1'b0;
         div_idx_ff     <= '0;
         scan_cnt_ff    <= '0;
         s1_v_ff        <= 1'b0;
         s2_v_ff        <= 1'b0;
         rd_v_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int j = 0; j < NUM_CLUSTERS; j++) begin
            centers_ff[j] <= (j == 0) ? 8'd0 : (j == 1) ? 8'd85 :
                             (j == 2) ? 8'd170 : 8'd255;
            sums_ff[j]    <= '0;
            counts_ff[j]  <= '0;
         end
      end else begin
         // Register writes
         if (csr_we) begin
            case (csr_index)
               CSR_INIT_C0:    init_ff[0]    <= csr_wdata;
               CSR_INIT_C1:    init_ff[1]    <= csr_wdata;
               CSR_INIT_C2:    init_ff[2]    <= csr_wdata;
               CSR_INIT_C3:    init_ff[3]    <= csr_wdata;
               CSR_MAX_PASSES: max_passes_ff <= csr_wdata;
               default: ;
            endcase
         end

         // Scan pipeline: store read, label, accumulate
         s1_v_ff   <= (state_ff == S_SCAN);
         s2_v_ff   <= s1_v_ff;
         s2_lbl_ff <= near.lbl;
         s2_px_ff  <= mem_q;
         if (s2_v_ff) begin
            for (int j = 0; j < NUM_CLUSTERS; j++) begin
               if (s2_lbl_ff == LBL_W'(j)) begin
                  sums_ff[j]   <= sums_ff[j] + SUM_W'(s2_px_ff);
                  counts_ff[j] <= counts_ff[j] + COUNT_W'(1);
               end
            end
         end

         // Readout pipeline
         rd_v_ff      <= read_acc;
         rd_last_ff   <= ((rd_ptr_ff + COUNT_W'(1)) == pix_count_ff);
         rsp_valid_ff <= rd_v_ff;
         rsp_value_ff <= near.val;
         rsp_label_ff <= lbl_ext[1:0];
         rsp_last_ff  <= rd_last_ff;
         rsp_conv_ff  <= conv_ff;
         if (read_acc) begin
            rd_ptr_ff <= rd_ptr_ff + COUNT_W'(1);
         end

         // Loads; overflow loads are dropped, the count saturates
         if (load_acc) begin
            pix_count_ff   <= load_room ? (load_base + COUNT_W'(1)) : load_base;
            rd_ptr_ff      <= '0;
            frame_ready_ff <= req_last;
            if (req_last) begin
               state_ff <= S_INIT;
            end
         end

         // Clustering sequencer
         case (state_ff)
            S_IDLE: ;
            S_INIT: begin
               for (int j = 0; j < NUM_CLUSTERS; j++) begin
                  centers_ff[j] <= init_ff[(j < 4) ? j : 3];
               end
               pass_ff  <= '0;
               conv_ff  <= 1'b0;
               state_ff <= (max_passes_ff == '0) ? S_IDLE : S_CLEAR;
            end
            S_CLEAR: begin
               for (int j = 0; j < NUM_CLUSTERS; j++) begin
                  sums_ff[j]   <= '0;
                  counts_ff[j] <= '0;
               end
               scan_cnt_ff <= '0;
               changed_ff  <= 1'b0;
               div_idx_ff  <= '0;
               state_ff    <= S_SCAN;
            end
            S_SCAN: begin
               scan_cnt_ff <= scan_cnt_ff + COUNT_W'(1);
               if ((scan_cnt_ff + COUNT_W'(1)) == pix_count_ff) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (!s1_v_ff && !s2_v_ff) begin
                  state_ff <= S_DIV_SEL;
               end
            end
            S_DIV_SEL: begin
               // empty cluster keeps its centre
               if (counts_ff[div_idx_ff] == '0) begin
                  if (last_idx) begin
                     state_ff <= S_PASS_END;
                  end else begin
                     div_idx_ff <= div_idx_ff + LBL_W'(1);
                  end
               end else begin
                  state_ff <= S_DIV_WAIT;
               end
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  for (int j = 0; j < NUM_CLUSTERS; j++) begin
                     if (div_idx_ff == LBL_W'(j) && mean_val != centers_ff[j]) begin
                        centers_ff[j] <= mean_val;
                        changed_ff    <= 1'b1;
                     end
                  end
                  if (last_idx) begin
                     state_ff <= S_PASS_END;
                  end else begin
                     div_idx_ff <= div_idx_ff + LBL_W'(1);
                     state_ff   <= S_DIV_SEL;
                  end
               end
            end
            S_PASS_END: begin
               pass_ff <= pass_ff + 8'd1;
               if (!changed_ff) begin
                  conv_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else if ((pass_ff + 8'd1) >= max_passes_ff) begin
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_CLEAR;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_label     = rsp_label_ff;
   assign rsp_last_out  = rsp_last_ff;
   assign rsp_converged = rsp_conv_ff;

endmodule

// ===== rtl/kmq_checker.sv =====
module kmq_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_func,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_last_out
);

   // A result only follows a read item taken earlier, via the store and output registers
   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_func, 2))
      else $error("result without a preceding read item");

   // Load items never produce a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_func) |-> ##2 !rsp_valid)
      else $error("result after a load item");

   // Clustering only starts from the final load of a frame
   a_busy_on_frame_end: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !req_func && req_last))
      else $error("busy without a frame-end load");

   // A read past the final pixel yields nothing
   a_end_of_readout: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_out && start && !busy && req_func) |=> !rsp_valid)
      else $error("result beyond the end of the frame");

endmodule

bind grayscale_kmeans_quantizer kmq_checker u_kmq_checker (.*);

// ===== bench/tb_grayscale_kmeans_quantizer.sv =====
`timescale 1ns / 100ps

module tb_grayscale_kmeans_quantizer;
   import kmq_pkg::*;

   localparam int     RANDOM_ITEMS = 1050;
   localparam longint CYCLE_LIMIT  = 10_000_000;
   localparam int     DIR_ROWS     = 25;

   typedef enum bit {
      OP_LOAD = 1'b0,
      OP_READ = 1'b1
   } op_type;

   // how the pixels of a random frame are drawn
   typedef enum int {
      PX_UNIFORM,
      PX_GROUPED,
      PX_EXTREME,
      PX_FLAT
   } px_style_type;

   typedef struct packed {
      pixel_type  value;
      logic [1:0] label;
      logic       last_out;
      logic       converged;
   } quant_px_type;

   typedef struct packed {
      op_type       op;
      pixel_type    pixel;
      bit           last;
      bit           typed;
      quant_px_type want;
   } stim_row_type;

   localparam quant_px_type NO_PX = '0;

   // block ports
   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  start         = 1'b0;
   logic                  busy;
   logic                  req_func      = 1'b0;
   pixel_type             req_pixel     = '0;
   logic                  req_last      = 1'b0;
   logic                  rsp_valid;
   pixel_type             rsp_value;
   logic [1:0]            rsp_label;
   logic                  rsp_last_out;
   logic                  rsp_converged;
   logic                  csr_we        = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index     = '0;
   logic [CSR_DATA_W-1:0] csr_wdata     = '0;

   // quantiser state as the bench sees it
   pixel_type   pix_mem [FRAME_MAX];
   pixel_type   init_cen [4]          = '{8'd0, 8'd85, 8'd170, 8'd255};
   pixel_type   pass_cap              = 8'd64;
   pixel_type   cen [NUM_CLUSTERS]    = '{8'd0, 8'd85, 8'd170, 8'd255};
   int unsigned n_pix                 = 0;
   int unsigned rd_ptr                = 0;
   bit          conv_flag             = 1'b0;
   bit          frame_done            = 1'b0;

   // quantised pixels still owed by the block, oldest first
   quant_px_type pending_px [$];
   quant_px_type want_px;

   // random frame shaping
   px_style_type px_style             = PX_UNIFORM;
   pixel_type   base_px [4];
   bit          burst                 = 1'b0;

   int          mismatch_count        = 0;
   int          results_checked       = 0;
   int          items_done            = 0;
   int          n_loads               = 0;
   int          n_reads               = 0;
   int          n_frames              = 0;
   int          n_settings            = 0;
   longint      cycle_count           = 0;

   // directed items: typed results only where they are obvious
   stim_row_type dir_table [DIR_ROWS] = '{
      '{OP_READ, 8'd0,   1'b0, 1'b0, NO_PX},                          // no frame yet
      '{OP_LOAD, 8'd0,   1'b1, 1'b0, NO_PX},
      '{OP_READ, 8'd0,   1'b0, 1'b1, '{8'd0,   2'd0, 1'b1, 1'b1}},
      '{OP_READ, 8'd0,   1'b0, 1'b0, NO_PX},                          // past the end
      '{OP_LOAD, 8'd255, 1'b1, 1'b0, NO_PX},                          // restarts frame
      '{OP_READ, 8'd255, 1'b1, 1'b1, '{8'd255, 2'd3, 1'b1, 1'b1}},
      '{OP_LOAD, 8'd0,   1'b0, 1'b0, NO_PX},
      '{OP_LOAD, 8'd85,  1'b0, 1'b0, NO_PX},
      '{OP_LOAD, 8'd170, 1'b0, 1'b0, NO_PX},
      '{OP_LOAD, 8'd255, 1'b1, 1'b0, NO_PX},
      '{OP_READ, 8'd0,   1'b0, 1'b1, '{8'd0,   2'd0, 1'b0, 1'b1}},
      '{OP_READ, 8'd0,   1'b0, 1'b1, '{8'd85,  2'd1, 1'b0, 1'b1}},
      '{OP_READ, 8'd0,   1'b0, 1'b1, '{8'd170, 2'd2, 1'b0, 1'b1}},
      '{OP_READ, 8'd0,   1'b0, 1'b1, '{8'd255, 2'd3, 1'b1, 1'b1}},
      '{OP_READ, 8'd0,   1'b1, 1'b0, NO_PX},
      '{OP_LOAD, 8'd10,  1'b0, 1'b0, NO_PX},
      '{OP_LOAD, 8'd20,  1'b0, 1'b0, NO_PX},
      '{OP_LOAD, 8'd200, 1'b0, 1'b0, NO_PX},
      '{OP_LOAD, 8'd250, 1'b1, 1'b0, NO_PX},
      '{OP_READ, 8'd0,   1'b0, 1'b0, NO_PX},
      '{OP_READ, 8'd0,   1'b0, 1'b0, NO_PX},
      '{OP_LOAD, 8'd99,  1'b0, 1'b0, NO_PX},                          // cuts readout short
      '{OP_LOAD, 8'd1,   1'b1, 1'b0, NO_PX},
      '{OP_READ, 8'd0,   1'b0, 1'b0, NO_PX},
      '{OP_READ, 8'd0,   1'b0, 1'b0, NO_PX}
   };

   grayscale_kmeans_quantizer i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_pixel     (req_pixel),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_value     (rsp_value),
      .rsp_label     (rsp_label),
      .rsp_last_out  (rsp_last_out),
      .rsp_converged (rsp_converged),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #1 clock = ~clock;

   task automatic flag_mismatch(string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // nearest centre by absolute distance, lower index wins a tie
   function automatic logic [1:0] closest_centre(pixel_type px);
      int         best_d;
      int         d;
      logic [1:0] best;
      best   = 2'd0;
      best_d = 0;
      for (int j = 0; j < NUM_CLUSTERS; j++) begin
         d = int'(px) - int'(cen[j]);
         if (d < 0) d = -d;
         if (j == 0 || d < best_d) begin
            best_d = d;
            best   = 2'(j);
         end
      end
      return best;
   endfunction

   // Lloyd passes over the stored frame, from the programmed centres
   function automatic void run_lloyd();
      longint unsigned sums [NUM_CLUSTERS];
      int unsigned     cnts [NUM_CLUSTERS];
      int unsigned     passes;
      logic [1:0]      lab;
      pixel_type       mean;
      bit              moved;
      for (int j = 0; j < NUM_CLUSTERS; j++) cen[j] = init_cen[(j < 4) ? j : 3];
      passes    = 0;
      conv_flag = 1'b0;
      while (passes < pass_cap) begin
         moved = 1'b0;
         for (int j = 0; j < NUM_CLUSTERS; j++) begin
            sums[j] = 0;
            cnts[j] = 0;
         end
         for (int unsigned i = 0; i < n_pix; i++) begin
            lab       = closest_centre(pix_mem[i]);
            sums[lab] += pix_mem[i];
            cnts[lab]++;
         end
         // empty clusters keep their centre
         for (int j = 0; j < NUM_CLUSTERS; j++) begin
            if (cnts[j] != 0) begin
               mean = pixel_type'(sums[j] / cnts[j]);
               if (mean != cen[j]) begin
                  cen[j] = mean;
                  moved  = 1'b1;
               end
            end
         end
         passes++;
         if (!moved) begin
            conv_flag = 1'b1;
            break;
         end
      end
   endfunction

   // one accepted item: update the state, return 1 if a pixel comes back
   function automatic bit quantise_item(op_type op, pixel_type px, bit last,
                                        output quant_px_type res);
      logic [1:0] lab;
      res = '0;
      if (op == OP_LOAD) begin
         if (frame_done) begin
            frame_done = 1'b0;
            n_pix      = 0;
            rd_ptr     = 0;
         end
         // beyond the store the load is dropped, but last still counts
         if (n_pix < FRAME_MAX) begin
            pix_mem[n_pix] = px;
            n_pix++;
         end
         if (last) begin
            run_lloyd();
            rd_ptr     = 0;
            frame_done = 1'b1;
            n_frames++;
         end
         return 1'b0;
      end
      if (!frame_done || rd_ptr >= n_pix) return 1'b0;
      lab           = closest_centre(pix_mem[rd_ptr]);
      res.value     = cen[lab];
      res.label     = lab;
      res.last_out  = (rd_ptr + 1 == n_pix);
      res.converged = conv_flag;
      rd_ptr++;
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic pixel_type pick_pixel();
      int v;
      case (px_style)
         PX_UNIFORM: v = $urandom_range(0, 255);
         PX_GROUPED: begin
            v = int'(base_px[$urandom_range(0, 3)]) + int'($urandom_range(0, 12)) - 6;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
         end
         PX_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       v = 0;
               1:       v = 255;
               2:       v = 1;
               default: v = 254;
            endcase
         end
         default:    v = int'(base_px[0]);
      endcase
      return pixel_type'(v);
   endfunction

   // present one item and hold it until the block takes it
   task automatic send_item(op_type op, pixel_type px, bit last, bit typed,
                            quant_px_type want);
      quant_px_type res;
      bit           got;
      req_func  <= op;
      req_pixel <= px;
      req_last  <= last;
      start     <= 1'b1;
      do @(posedge clock); while (busy);
      got = quantise_item(op, px, last, res);
      if (op == OP_LOAD) n_loads++;
      else n_reads++;
      if (got) pending_px.push_back(typed ? want : res);
      items_done++;
   endtask

   task automatic pace();
      int gap;
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_all_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_px.size() != 0) @(posedge clock);
   endtask

   // idle point for register writes: nothing owed and no clustering running
   task automatic settle_block();
      wait_all_results();
      repeat (2) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, pixel_type val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_INIT_C0:    init_cen[0] = val;
         CSR_INIT_C1:    init_cen[1] = val;
         CSR_INIT_C2:    init_cen[2] = val;
         CSR_INIT_C3:    init_cen[3] = val;
         CSR_MAX_PASSES: pass_cap    = val;
         default: ;
      endcase
   endtask

   task automatic program_setup(pixel_type c0, pixel_type c1, pixel_type c2, pixel_type c3,
                                pixel_type cap);
      write_reg(CSR_INIT_C0, c0);
      write_reg(CSR_INIT_C1, c1);
      write_reg(CSR_INIT_C2, c2);
      write_reg(CSR_INIT_C3, c3);
      write_reg(CSR_MAX_PASSES, cap);
      csr_we <= 1'b0;
      n_settings++;
   endtask

   // extremes first, then random centres and caps
   task automatic setup_phase(int phase);
      int r;
      case (phase)
         0: program_setup(8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
         1: program_setup(8'd255, 8'd255, 8'd255, 8'd255, 8'd1);
         2: program_setup(8'd0, 8'd85, 8'd170, 8'd255, 8'd0);
         3: program_setup(8'd255, 8'd170, 8'd85, 8'd0, 8'd2);
         4: program_setup(8'd0, 8'd255, 8'd0, 8'd255, 8'd255);
         default: begin
            r = $urandom_range(0, 9);
            program_setup(pixel_type'($urandom_range(0, 255)),
                          pixel_type'($urandom_range(0, 255)),
                          pixel_type'($urandom_range(0, 255)),
                          pixel_type'($urandom_range(0, 255)),
                          (r == 0) ? 8'd0 : (r == 1) ? 8'd1 : (r == 2) ? 8'd255 :
                          pixel_type'($urandom_range(1, 40)));
         end
      endcase
   endtask

   // a frame of loads with stray reads, then a readout that may be cut short or run past the end
   task automatic run_random_frame();
      int n_load;
      int n_read;
      burst    = ($urandom_range(0, 3) == 0);
      px_style = px_style_type'($urandom_range(0, 3));
      for (int b = 0; b < 4; b++) base_px[b] = pixel_type'($urandom_range(0, 255));
      n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      for (int k = 0; k < n_load; k++) begin
         if ($urandom_range(0, 11) == 0) begin
            send_item(OP_READ, pixel_type'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'b0, NO_PX);
            pace();
         end
         send_item(OP_LOAD, pick_pixel(), (k == n_load - 1) || ($urandom_range(0, 59) == 0),
                   1'b0, NO_PX);
         pace();
      end
      n_read = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n_load)
                                           : n_load + $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) wait_all_results();
      for (int k = 0; k < n_read; k++) begin
         send_item(OP_READ, pixel_type'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'b0, NO_PX);
         pace();
      end
   endtask

   // result checker: every strobe takes the oldest owed pixel
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_px.size() == 0) begin
            flag_mismatch($sformatf("result with nothing owed: value %0d label %0d",
                                    rsp_value, rsp_label));
         end else begin
            want_px = pending_px.pop_front();
            results_checked++;
            if (rsp_value !== want_px.value)
               flag_mismatch($sformatf("result %0d value %0d, want %0d",
                                       results_checked, rsp_value, want_px.value));
            if (rsp_label !== want_px.label)
               flag_mismatch($sformatf("result %0d label %0d, want %0d",
                                       results_checked, rsp_label, want_px.label));
            if (rsp_last_out !== want_px.last_out)
               flag_mismatch($sformatf("result %0d last_out %0b, want %0b",
                                       results_checked, rsp_last_out, want_px.last_out));
            if (rsp_converged !== want_px.converged)
               flag_mismatch($sformatf("result %0d converged %0b, want %0b",
                                       results_checked, rsp_converged, want_px.converged));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d results owed",
                  cycle_count, pending_px.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int phase;
      int n_phase_frames;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed items under the reset register values
      for (int k = 0; k < DIR_ROWS; k++) begin
         send_item(dir_table[k].op, dir_table[k].pixel, dir_table[k].last,
                   dir_table[k].typed, dir_table[k].want);
         pace();
      end

      // random frames over a sequence of register settings
      phase = 0;
      while (items_done < RANDOM_ITEMS) begin
         settle_block();
         setup_phase(phase);
         phase++;
         n_phase_frames = $urandom_range(2, 5);
         for (int f = 0; f < n_phase_frames && items_done < RANDOM_ITEMS; f++)
            run_random_frame();
      end

      // a small back-to-back frame to finish
      px_style = PX_UNIFORM;
      for (int k = 0; k < 3; k++) send_item(OP_LOAD, pick_pixel(), k == 2, 1'b0, NO_PX);
      for (int k = 0; k < 4; k++) send_item(OP_READ, 8'd0, 1'b0, 1'b0, NO_PX);

      wait_all_results();
      repeat (4) @(posedge clock);

      $display("covered %0d loads and %0d reads, %0d quantised pixels checked, %0d frames",
               n_loads, n_reads, results_checked, n_frames);
      $display("over %0d register settings incl. zero and full pass caps, cut-short readouts",
               n_settings);
      if (mismatch_count == 0 && pending_px.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/kmq_pkg.sv
rtl/kmq_pixel_ram.sv
rtl/kmq_divider.sv
rtl/grayscale_kmeans_quantizer.sv
rtl/kmq_checker.sv
bench/tb_grayscale_kmeans_quantizer.sv
